// ----- hdl/tet_pkg.sv -----
// ----------------------------------------------------------------------------
// Touch event tracker package
// Shared widths, register indexes and event codes for the touch tracker.
// ----------------------------------------------------------------------------
package tet_pkg;

  // Calibration and screen size registers are all this wide.
  localparam int unsigned CFG_W    = 12;
  // Move threshold register width; also the width of the write data.
  localparam int unsigned THR_W    = 25;
  localparam int unsigned CFG_IDX_W = 3;
  // Scale factor is kept to this many bits after the division.
  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned SCREEN_W = 18;
  localparam int unsigned KIND_W   = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR   = 3'd6;

  // Register values after reset.
  localparam logic [CFG_W-1:0] RST_CAL_MIN_X = 12'd620;
  localparam logic [CFG_W-1:0] RST_CAL_MIN_Y = 12'd490;
  localparam logic [CFG_W-1:0] RST_CAL_MAX_X = 12'd2900;
  localparam logic [CFG_W-1:0] RST_CAL_MAX_Y = 12'd3130;
  localparam logic [CFG_W-1:0] RST_SCREEN_W  = 12'd176;
  localparam logic [CFG_W-1:0] RST_SCREEN_H  = 12'd220;
  localparam logic [THR_W-1:0] RST_MOVE_THR  = 25'd2304;

  // Event codes carried on the result channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

endpackage

// ----- hdl/tet_div.sv -----
// ----------------------------------------------------------------------------
// Touch tracker scale divider
// Restoring divider, one quotient bit per cycle; keeps the low quotient bits.
// ----------------------------------------------------------------------------
module tet_div #(
  parameter int unsigned DVD_W = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DVD_W-1:0]              dividend_i,
  input  logic [tet_pkg::CFG_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [tet_pkg::FACTOR_W-1:0]  quot_o
);
  import tet_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [CFG_W-1:0] rem_q;
  logic [FACTOR_W-1:0] quot_q;

  logic [CFG_W:0]   trial;
  logic             fits;
  logic [CFG_W:0]   diff;

  // Bring down the next dividend bit and try one subtraction.
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    fits  = (trial >= {1'b0, divisor_i});
    diff  = trial - {1'b0, divisor_i};
  end

  // Sequencer and datapath registers of the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q  <= dividend_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q  <= fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
      quot_q <= {quot_q[FACTOR_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- hdl/touch_event_tracker.sv -----
// ----------------------------------------------------------------------------
// Touch event tracker
// Turns averaged touch-panel samples into begin, move and end events with
// raw and screen coordinates.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Beat contents
//  sample    in         in_valid_i / in_ready_o   sample_x_i, sample_y_i
//  event     out        out_valid_o / out_ready_i event_kind_o, event_x_o,
//                                                 event_y_o, screen_x_o, screen_y_o
//  config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  A sample that gives no event is only classified; a small move also squares
//  both distances and compares their sum. An event runs the bit-serial divider,
//  once per axis for the scale factor, and a multiply for each screen coordinate.
//  One shared multiplier forms both squared distances and both screen products.
//  The event register frees the input side; a stalled event holds back the next
//  event and the input. Reset restores the calibration defaults and ends any touch.
// ----------------------------------------------------------------------------
module touch_event_tracker #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned SCALE_SHIFT = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [tet_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tet_pkg::THR_W-1:0]       cfg_data_i,
  // Sample input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [SAMPLE_BITS-1:0]          sample_x_i,
  input  logic [SAMPLE_BITS-1:0]          sample_y_i,
  // Event output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tet_pkg::KIND_W-1:0]      event_kind_o,
  output logic [SAMPLE_BITS-1:0]          event_x_o,
  output logic [SAMPLE_BITS-1:0]          event_y_o,
  output logic [tet_pkg::SCREEN_W-1:0]    screen_x_o,
  output logic [tet_pkg::SCREEN_W-1:0]    screen_y_o
);
  import tet_pkg::*;

  // Compare width for samples against calibration values.
  localparam int unsigned CMP_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  // Product bits needed for the screen coordinate after the shift.
  localparam int unsigned PRD_W = SCALE_SHIFT + SCREEN_W;
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS;
  localparam int unsigned MUL_W = (PRD_W > SQ_W) ? PRD_W : SQ_W;
  localparam int unsigned FULL_W = MUL_W + FACTOR_W;
  localparam int unsigned SUM_W0 = SQ_W + 1;
  localparam int unsigned SUM_W = (SUM_W0 > THR_W) ? SUM_W0 : THR_W;
  localparam int unsigned DVD_W = CFG_W + SCALE_SHIFT;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQX,
    ST_SQY,
    ST_CMP,
    ST_DIV_X,
    ST_MUL_X,
    ST_DIV_Y,
    ST_MUL_Y,
    ST_OUT
  } state_e;

  // Configuration registers
  logic [CFG_W-1:0] cal_min_x_q, cal_min_y_q, cal_max_x_q, cal_max_y_q;
  logic [CFG_W-1:0] scr_w_q, scr_h_q;
  logic [THR_W-1:0] move_thr_q;

  // Sequencer state and working registers
  state_e               state_q;
  logic                 active_q;
  logic                 div_start_q;
  logic [SAMPLE_BITS-1:0] smp_x_q, smp_y_q;
  logic [SAMPLE_BITS-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  kind_e                ev_kind_q;
  logic [SAMPLE_BITS-1:0] ev_x_q, ev_y_q;
  logic [MUL_W-1:0]     acc_q, sq_y_q;
  logic [SCREEN_W-1:0]  scr_x_q, scr_y_q;

  // Event output register
  logic                 out_valid_q;
  kind_e                out_kind_q;
  logic [SAMPLE_BITS-1:0] out_x_q, out_y_q;
  logic [SCREEN_W-1:0]  out_sx_q, out_sy_q;

  logic                 below_min;
  logic [SAMPLE_BITS-1:0] dx, dy;
  logic [SUM_W-1:0]     sq_sum;
  logic                 moved;
  logic [MUL_W-1:0]     mul_a;
  logic [FACTOR_W-1:0]  mul_b;
  logic [FULL_W-1:0]    mul_full;
  logic [MUL_W-1:0]     mul_res;
  logic [PRD_W-1:0]     diff_x, diff_y;
  logic [DVD_W-1:0]     div_dvd;
  logic [CFG_W-1:0]     div_dsr;
  logic                 div_done;
  logic [FACTOR_W-1:0]  div_quot;
  logic [FACTOR_W-1:0]  factor_x, factor_y;
  logic                 out_free;

  // Sample classification and distances to the current position.
  always_comb begin
    below_min = (CMP_W'(smp_x_q) < CMP_W'(cal_min_x_q)) ||
                (CMP_W'(smp_y_q) < CMP_W'(cal_min_y_q));
    dx = (smp_x_q >= cur_x_q) ? (smp_x_q - cur_x_q) : (cur_x_q - smp_x_q);
    dy = (smp_y_q >= cur_y_q) ? (smp_y_q - cur_y_q) : (cur_y_q - smp_y_q);
    sq_sum = SUM_W'(acc_q[SQ_W-1:0]) + SUM_W'(sq_y_q[SQ_W-1:0]);
    moved  = (sq_sum > SUM_W'(move_thr_q));
  end

  // Offsets from the calibration minimum, two's complement modulo the product, and scale factors.
  always_comb begin
    diff_x = PRD_W'(ev_x_q) - PRD_W'(cal_min_x_q);
    diff_y = PRD_W'(ev_y_q) - PRD_W'(cal_min_y_q);
    factor_x = (cal_max_x_q > cal_min_x_q) ? div_quot : '0;
    factor_y = (cal_max_y_q > cal_min_y_q) ? div_quot : '0;
  end

  // Shared multiplier: squared distances, then screen products.
  always_comb begin
    unique case (state_q)
      ST_SQX: begin
        mul_a = MUL_W'(dx);
        mul_b = FACTOR_W'(dx);
      end
      ST_SQY: begin
        mul_a = MUL_W'(dy);
        mul_b = FACTOR_W'(dy);
      end
      ST_MUL_X: begin
        mul_a = MUL_W'(diff_x);
        mul_b = factor_x;
      end
      ST_MUL_Y: begin
        mul_a = MUL_W'(diff_y);
        mul_b = factor_y;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = FULL_W'(mul_a) * FULL_W'(mul_b);
    mul_res  = mul_full[MUL_W-1:0];
  end

  // Divider operands follow the axis being scaled.
  always_comb begin
    if (state_q == ST_DIV_Y) begin
      div_dvd = {scr_h_q, SCALE_SHIFT'(0)};
      div_dsr = cal_max_y_q - cal_min_y_q;
    end else begin
      div_dvd = {scr_w_q, SCALE_SHIFT'(0)};
      div_dsr = cal_max_x_q - cal_min_x_q;
    end
  end

  tet_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_min_x_q <= RST_CAL_MIN_X;
      cal_min_y_q <= RST_CAL_MIN_Y;
      cal_max_x_q <= RST_CAL_MAX_X;
      cal_max_y_q <= RST_CAL_MAX_Y;
      scr_w_q     <= RST_SCREEN_W;
      scr_h_q     <= RST_SCREEN_H;
      move_thr_q  <= RST_MOVE_THR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAL_MIN_X: cal_min_x_q <= cfg_data_i[CFG_W-1:0];
        REG_CAL_MIN_Y: cal_min_y_q <= cfg_data_i[CFG_W-1:0];
        REG_CAL_MAX_X: cal_max_x_q <= cfg_data_i[CFG_W-1:0];
        REG_CAL_MAX_Y: cal_max_y_q <= cfg_data_i[CFG_W-1:0];
        REG_SCREEN_W:  scr_w_q     <= cfg_data_i[CFG_W-1:0];
        REG_SCREEN_H:  scr_h_q     <= cfg_data_i[CFG_W-1:0];
        REG_MOVE_THR:  move_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer, tracking state and event output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      div_start_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            smp_x_q <= sample_x_i;
            smp_y_q <= sample_y_i;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (below_min) begin
            if (active_q) begin
              active_q    <= 1'b0;
              ev_kind_q   <= KIND_END;
              ev_x_q      <= prev_x_q;
              ev_y_q      <= prev_y_q;
              div_start_q <= 1'b1;
              state_q     <= ST_DIV_X;
            end else begin
              state_q <= ST_IDLE;
            end
          end else if (!active_q) begin
            active_q    <= 1'b1;
            cur_x_q     <= smp_x_q;
            cur_y_q     <= smp_y_q;
            prev_x_q    <= smp_x_q;
            prev_y_q    <= smp_y_q;
            ev_kind_q   <= KIND_BEGIN;
            ev_x_q      <= smp_x_q;
            ev_y_q      <= smp_y_q;
            div_start_q <= 1'b1;
            state_q     <= ST_DIV_X;
          end else begin
            state_q <= ST_SQX;
          end
        end
        ST_SQX: begin
          acc_q   <= mul_res;
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          sq_y_q  <= mul_res;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (moved) begin
            prev_x_q    <= cur_x_q;
            prev_y_q    <= cur_y_q;
            cur_x_q     <= smp_x_q;
            cur_y_q     <= smp_y_q;
            ev_kind_q   <= KIND_MOVE;
            ev_x_q      <= cur_x_q;
            ev_y_q      <= cur_y_q;
            div_start_q <= 1'b1;
            state_q     <= ST_DIV_X;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIV_X: begin
          if (div_done) begin
            state_q <= ST_MUL_X;
          end
        end
        ST_MUL_X: begin
          scr_x_q     <= mul_res[PRD_W-1:SCALE_SHIFT];
          div_start_q <= 1'b1;
          state_q     <= ST_DIV_Y;
        end
        ST_DIV_Y: begin
          if (div_done) begin
            state_q <= ST_MUL_Y;
          end
        end
        ST_MUL_Y: begin
          scr_y_q <= mul_res[PRD_W-1:SCALE_SHIFT];
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // Hand the event over once the output register is free.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= ev_kind_q;
            out_x_q     <= ev_x_q;
            out_y_q     <= ev_y_q;
            out_sx_q    <= scr_x_q;
            out_sy_q    <= scr_y_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign event_x_o    = out_x_q;
  assign event_y_o    = out_y_q;
  assign screen_x_o   = out_sx_q;
  assign screen_y_o   = out_sy_q;

endmodule
